FILE: sv/cov_rec_pkg.sv
`default_nettype none

package cov_rec_pkg;

  localparam int MAP_ENTRIES_DEF = 65536;
  localparam int MAX_ENTRIES_DEF = 512;

  localparam logic [3:0] CMD_XOR     = 4'd0;
  localparam logic [3:0] CMD_PUSH    = 4'd1;
  localparam logic [3:0] CMD_INC     = 4'd2;
  localparam logic [3:0] CMD_SET     = 4'd3;
  localparam logic [3:0] CMD_MAX     = 4'd4;
  localparam logic [3:0] CMD_MIN     = 4'd5;
  localparam logic [3:0] CMD_RESTART = 4'd6;
  localparam logic [3:0] CMD_RD_CNT  = 4'd7;
  localparam logic [3:0] CMD_RD_MAX  = 4'd8;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] addr;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] state_now;
    logic [63:0] read_data;
    logic        updated;
  } out_word_t;

  typedef struct packed {
    logic hit_we;
    logic max_we;
    logic updated;
  } wr_ctl_t;

endpackage

`default_nettype wire

FILE: sv/cov_rec_update.sv
`default_nettype none

module cov_rec_update #(
  parameter int MAP_AW = 16
) (
  input  logic [3:0]          cmd,
  input  logic [63:0]         value,
  input  logic [MAP_AW-1:0]   ps,
  input  logic [31:0]         hist,
  input  logic [7:0]          hit_rd,
  input  logic [63:0]         max_rd,
  output logic [MAP_AW-1:0]   ps_nxt,
  output logic [31:0]         hist_nxt,
  output logic [7:0]          hit_wdata,
  output logic [63:0]         max_wdata,
  output logic [63:0]         read_data,
  output cov_rec_pkg::wr_ctl_t ctl
);

  logic [31:0] hist_push;
  logic [63:0] operand;
  logic        larger;

  assign hist_push = {hist[23:0], value[7:0]};
  // A min update is a max update on the complemented operand.
  assign operand   = (cmd == cov_rec_pkg::CMD_MIN) ? (cov_rec_pkg::ALL_ONES - value) : value;
  assign larger    = max_rd < operand;
  assign max_wdata = operand;

  always_comb begin
    ps_nxt    = ps;
    hist_nxt  = hist;
    hit_wdata = hit_rd;
    read_data = 64'd0;
    ctl       = '0;
    case (cmd)
      cov_rec_pkg::CMD_XOR: begin
        ps_nxt = ps ^ value[MAP_AW-1:0];
      end
      cov_rec_pkg::CMD_PUSH: begin
        ps_nxt   = ps ^ hist[MAP_AW-1:0] ^ hist_push[MAP_AW-1:0];
        hist_nxt = hist_push;
      end
      cov_rec_pkg::CMD_INC: begin
        hit_wdata  = hit_rd + 8'd1;
        ctl.hit_we = 1'b1;
      end
      cov_rec_pkg::CMD_SET: begin
        hit_wdata  = hit_rd | 8'd1;
        ctl.hit_we = 1'b1;
      end
      cov_rec_pkg::CMD_MAX, cov_rec_pkg::CMD_MIN: begin
        ctl.max_we  = larger;
        ctl.updated = larger;
      end
      cov_rec_pkg::CMD_RESTART: begin
        ps_nxt     = '0;
        hist_nxt   = 32'd0;
        hit_wdata  = 8'd1;
        ctl.hit_we = 1'b1;
      end
      cov_rec_pkg::CMD_RD_CNT: begin
        read_data = {56'd0, hit_rd};
      end
      cov_rec_pkg::CMD_RD_MAX: begin
        read_data = max_rd;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/coverage_state_map_recorder_core.sv
`default_nettype none

// An accepted word and its reads are registered; execute loads the output register once it is free.
// The map memories take a read then a write, so the next word is accepted only after execute.
// A waiting result does not block acceptance of the next word.
// Reset: a clearing pass over max(MAP_ENTRIES, MAX_ENTRIES) addresses (65536 by default)
// zeroes both memories; in_ready stays low until it ends.
// Table sizes must be powers of two, which the block does not check; indexes are the low address bits.
module coverage_state_map_recorder_core #(
  parameter int MAP_ENTRIES = cov_rec_pkg::MAP_ENTRIES_DEF,
  parameter int MAX_ENTRIES = cov_rec_pkg::MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cov_rec_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cov_rec_pkg::out_word_t out_data
);

  localparam int MAP_AW = $clog2(MAP_ENTRIES);
  localparam int MAX_AW = $clog2(MAX_ENTRIES);
  localparam int CLR_N  = (MAP_ENTRIES > MAX_ENTRIES) ? MAP_ENTRIES : MAX_ENTRIES;
  localparam int CLR_AW = $clog2(CLR_N);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r;

  logic [CLR_AW-1:0] clr_cnt_r;
  logic              clr_last;
  logic              clr_hit;
  logic              clr_max;

  logic [MAP_AW-1:0] ps_r;
  logic [31:0]       hist_r;

  logic [3:0]        cmd_r;
  logic [63:0]       value_r;
  logic [MAP_AW-1:0] hit_idx_r;
  logic [MAX_AW-1:0] max_idx_r;

  logic [MAP_AW-1:0] hit_idx;
  logic [MAX_AW-1:0] max_idx;

  logic [7:0]  hit_mem [MAP_ENTRIES];
  logic [63:0] max_mem [MAX_ENTRIES];
  logic [7:0]  hit_rd_r;
  logic [63:0] max_rd_r;

  logic              hit_we;
  logic [MAP_AW-1:0] hit_wa;
  logic [7:0]        hit_wd;
  logic              max_we;
  logic [MAX_AW-1:0] max_wa;
  logic [63:0]       max_wd;

  logic [MAP_AW-1:0]   ps_nxt;
  logic [31:0]         hist_nxt;
  logic [7:0]          upd_hit_wd;
  logic [63:0]         upd_max_wd;
  logic [63:0]         upd_rd;
  cov_rec_pkg::wr_ctl_t ctl;

  logic                  in_fire;
  logic                  exec_fire;
  logic                  out_valid_r;
  cov_rec_pkg::out_word_t out_data_r;
  logic [MAP_AW+15:0]    ps_wide;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign clr_last = (clr_cnt_r == CLR_AW'(CLR_N - 1));
  assign clr_hit  = (state_r == ST_CLEAR) && ({1'b0, clr_cnt_r} < (CLR_AW + 1)'(MAP_ENTRIES));
  assign clr_max  = (state_r == ST_CLEAR) && ({1'b0, clr_cnt_r} < (CLR_AW + 1)'(MAX_ENTRIES));

  // Counter reads use the raw address and restart uses counter zero; other commands fold the path state in.
  always_comb begin
    case (in_data.cmd)
      cov_rec_pkg::CMD_RD_CNT:  hit_idx = in_data.addr[MAP_AW-1:0];
      cov_rec_pkg::CMD_RESTART: hit_idx = '0;
      default:                  hit_idx = ps_r ^ in_data.addr[MAP_AW-1:0];
    endcase
  end
  assign max_idx = in_data.addr[MAX_AW-1:0];

  cov_rec_update #(
    .MAP_AW (MAP_AW)
  ) u_update (
    .cmd       (cmd_r),
    .value     (value_r),
    .ps        (ps_r),
    .hist      (hist_r),
    .hit_rd    (hit_rd_r),
    .max_rd    (max_rd_r),
    .ps_nxt    (ps_nxt),
    .hist_nxt  (hist_nxt),
    .hit_wdata (upd_hit_wd),
    .max_wdata (upd_max_wd),
    .read_data (upd_rd),
    .ctl       (ctl)
  );

  assign hit_we = clr_hit || (exec_fire && ctl.hit_we);
  assign hit_wa = (state_r == ST_CLEAR) ? clr_cnt_r[MAP_AW-1:0] : hit_idx_r;
  assign hit_wd = (state_r == ST_CLEAR) ? 8'd0 : upd_hit_wd;
  assign max_we = clr_max || (exec_fire && ctl.max_we);
  assign max_wa = (state_r == ST_CLEAR) ? clr_cnt_r[MAX_AW-1:0] : max_idx_r;
  assign max_wd = (state_r == ST_CLEAR) ? 64'd0 : upd_max_wd;

  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_wa] <= hit_wd;
    end
    if (in_fire) begin
      hit_rd_r <= hit_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (max_we) begin
      max_mem[max_wa] <= max_wd;
    end
    if (in_fire) begin
      max_rd_r <= max_mem[max_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + CLR_AW'(1);
          if (clr_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= '0;
      hist_r <= 32'd0;
    end else if (exec_fire) begin
      ps_r   <= ps_nxt;
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_data.cmd;
      value_r   <= in_data.value;
      hit_idx_r <= hit_idx;
      max_idx_r <= max_idx;
    end
  end

  assign ps_wide = {16'd0, ps_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r.state_now <= ps_wide[15:0];
      out_data_r.read_data <= upd_rd;
      out_data_r.updated   <= ctl.updated;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("result register not loaded after execute");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted word did not enter execute");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_reads_keep_state: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (cmd_r == cov_rec_pkg::CMD_RD_CNT || cmd_r == cov_rec_pkg::CMD_RD_MAX)
    |=> $stable(ps_r) && $stable(hist_r))
    else $error("read command changed the path state");

  a_update_writes: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && ctl.updated |-> max_we && (max_wa == max_idx_r))
    else $error("reported update without a table write");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cov_rec_pkg::*;

  localparam logic [31:0] MAP_MASK = 32'(MAP_ENTRIES_DEF - 1);
  localparam logic [31:0] MAX_MASK = 32'(MAX_ENTRIES_DEF - 1);
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam int RANDOM_WORDS = 1600;

  // Mirror of the recorder state; it predicts the answer to each accepted command
  // word and checks the answers that come back.
  class recorder_mirror;
    logic [31:0] path_state;
    logic [31:0] history;
    logic [7:0]  hit_cnt [MAP_ENTRIES_DEF];
    logic [63:0] max_tbl [MAX_ENTRIES_DEF];
    out_word_t   answers_due [$];
    int errors;
    int answers_checked;
    int wraps;
    int stores;
    int unused_cmds;
    int cmd_hist [16];

    function new();
      path_state = '0;
      history = '0;
      foreach (hit_cnt[i]) hit_cnt[i] = '0;
      foreach (max_tbl[i]) max_tbl[i] = '0;
      foreach (cmd_hist[i]) cmd_hist[i] = 0;
      errors = 0;
      answers_checked = 0;
      wraps = 0;
      stores = 0;
      unused_cmds = 0;
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function bit keep_larger(input logic [31:0] addr, input logic [63:0] v);
      logic [31:0] i;
      i = addr & MAX_MASK;
      if (max_tbl[i] < v) begin
        max_tbl[i] = v;
        stores++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_command(input in_word_t w);
      out_word_t want;
      logic [31:0] i;
      want = '0;
      cmd_hist[w.cmd]++;
      case (w.cmd)
        CMD_XOR: begin
          path_state = (path_state ^ w.value[31:0]) & MAP_MASK;
        end
        CMD_PUSH: begin
          path_state = (path_state ^ history) & MAP_MASK;
          history = {history[23:0], w.value[7:0]};
          path_state = (path_state ^ history) & MAP_MASK;
        end
        CMD_INC: begin
          i = (path_state ^ w.addr) & MAP_MASK;
          if (hit_cnt[i] == 8'hff) wraps++;
          hit_cnt[i] = hit_cnt[i] + 8'd1;
        end
        CMD_SET: begin
          i = (path_state ^ w.addr) & MAP_MASK;
          hit_cnt[i] = hit_cnt[i] | 8'd1;
        end
        CMD_MAX: begin
          want.updated = keep_larger(w.addr, w.value);
        end
        CMD_MIN: begin
          want.updated = keep_larger(w.addr, ALL_ONES - w.value);
        end
        CMD_RESTART: begin
          path_state = '0;
          history = '0;
          hit_cnt[0] = 8'd1;
        end
        CMD_RD_CNT: begin
          want.read_data = {56'd0, hit_cnt[w.addr & MAP_MASK]};
        end
        CMD_RD_MAX: begin
          want.read_data = max_tbl[w.addr & MAX_MASK];
        end
        default: begin
          unused_cmds++;
        end
      endcase
      want.state_now = path_state[15:0];
      answers_due.push_back(want);
    endfunction

    task check_answer(input out_word_t got);
      out_word_t want;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected, state_now=%h", got.state_now));
        return;
      end
      want = answers_due.pop_front();
      answers_checked++;
      if (got.state_now !== want.state_now)
        report_mismatch($sformatf("result %0d state_now got %h want %h",
                                  answers_checked, got.state_now, want.state_now));
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("result %0d read_data got %h want %h",
                                  answers_checked, got.read_data, want.read_data));
      if (got.updated !== want.updated)
        report_mismatch($sformatf("result %0d updated got %b want %b",
                                  answers_checked, got.updated, want.updated));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  recorder_mirror mirror;
  int words_sent = 0;
  bit steady = 1'b0;

  coverage_state_map_recorder_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: the worst legal run, memory clearing pass included, finishes before this fires.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return ALL_ONES;
      2: return 64'($urandom_range(0, 255));
      3: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Most sites come from a small pool so that counters are hit more than once.
  function automatic logic [31:0] pick_site();
    logic [31:0] a;
    a = 32'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) a = $urandom;
    else if ($urandom_range(0, 1) == 1) a[31:16] = 16'($urandom);
    return a;
  endfunction

  function automatic logic [31:0] pick_slot();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 4) != 0)
      a[8:0] = ($urandom_range(0, 5) == 0) ? 9'h1ff : 9'($urandom_range(0, 63));
    return a;
  endfunction

  // Counter reads are not xored with the path state, so fold it in here to read
  // back the counter that an increment at this site just touched.
  function automatic logic [31:0] hit_addr(input logic [31:0] site);
    logic [31:0] a;
    a = $urandom;
    return (a & ~MAP_MASK) | ((mirror.path_state ^ site) & MAP_MASK);
  endfunction

  task automatic send(input logic [3:0] cmd, input logic [31:0] addr, input logic [63:0] value);
    in_word_t w;
    int gap;
    w.cmd = cmd;
    w.addr = addr;
    w.value = value;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    mirror.note_command(w);
    words_sent++;
    if (words_sent % 100 == 0) steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (mirror != null && rst_n && out_valid === 1'b1 && out_ready)
      mirror.check_answer(out_data);
  end

  initial begin
    int on;
    int stall;
    forever begin
      on = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (on) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int kind;
    int n;
    int bursts;
    int rand_goal;
    int next_pause;
    logic [3:0]  c;
    logic [31:0] site;
    logic [31:0] a;
    mirror = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send(CMD_XOR, 32'h0, ALL_ONES);
    send(CMD_XOR, 32'hffff_ffff, 64'h0000_0000_1234_5678);
    send(CMD_PUSH, 32'h0, 64'hff);
    send(CMD_PUSH, 32'hffff_ffff, 64'h0);
    send(CMD_PUSH, 32'h0, ALL_ONES);
    send(CMD_INC, 32'hffff_ffff, 64'h0);
    send(CMD_SET, 32'hffff_ffff, ALL_ONES);
    send(CMD_RD_CNT, hit_addr(32'hffff_ffff), 64'h0);
    send(CMD_MAX, 32'h0, ALL_ONES);
    send(CMD_MAX, 32'h0, 64'h0);
    send(CMD_MAX, 32'h200, 64'd5);
    send(CMD_MIN, 32'h1, 64'h0);
    send(CMD_MIN, 32'h1, ALL_ONES);
    send(CMD_MIN, 32'h2, ALL_ONES);
    send(CMD_RD_MAX, 32'hffff_fe00, 64'h0);
    send(CMD_RD_MAX, 32'h1, ALL_ONES);
    send(CMD_RD_MAX, 32'h1ff, 64'h0);
    send(CMD_RESTART, $urandom, ALL_ONES);
    send(CMD_RD_CNT, 32'h0, 64'h0);
    send(CMD_INC, 32'h0, 64'h0);
    // Upper address bits fall outside the map, so this set lands on counter zero.
    send(CMD_SET, 32'h0001_0000, 64'h0);
    send(CMD_RD_CNT, 32'hffff_0000, 64'h0);
    for (int k = CMD_UNUSED_LO; k <= CMD_UNUSED_HI; k++)
      send(4'(k), $urandom, {$urandom, $urandom});

    bursts = 0;
    rand_goal = words_sent + RANDOM_WORDS;
    next_pause = words_sent + 500;
    while (words_sent < rand_goal) begin
      kind = $urandom_range(0, 99);
      if (bursts == 0 || (kind < 2 && bursts < 3)) begin
        // 250 to 262 increments at one site, so that its counter can wrap past 0xff.
        send(CMD_RESTART, $urandom, pick_value());
        site = pick_site();
        n = $urandom_range(250, 262);
        repeat (n) send(CMD_INC, site, pick_value());
        send(CMD_RD_CNT, hit_addr(site), pick_value());
        bursts++;
      end else if (kind < 55) begin
        c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI))
                                         : 4'($urandom_range(0, 8));
        case (c)
          CMD_RD_CNT: a = ($urandom_range(0, 1) == 1) ? hit_addr(pick_site()) : $urandom;
          CMD_MAX, CMD_MIN, CMD_RD_MAX: a = pick_slot();
          default: a = pick_site();
        endcase
        send(c, a, pick_value());
      end else if (kind < 72) begin
        if ($urandom_range(0, 1) == 1) send(CMD_RESTART, $urandom, pick_value());
        repeat ($urandom_range(1, 4))
          send(($urandom_range(0, 1) == 1) ? CMD_PUSH : CMD_XOR, $urandom, pick_value());
        repeat ($urandom_range(1, 6))
          send(($urandom_range(0, 2) != 0) ? CMD_INC : CMD_SET, pick_site(), pick_value());
        repeat ($urandom_range(1, 3))
          send(CMD_RD_CNT, hit_addr(pick_site()), pick_value());
      end else if (kind < 85) begin
        site = pick_slot();
        repeat ($urandom_range(1, 5)) begin
          a = (32'($urandom) & ~MAX_MASK) | (site & MAX_MASK);
          send(($urandom_range(0, 1) == 1) ? CMD_MAX : CMD_MIN, a,
               ($urandom_range(0, 3) == 0) ? pick_value() : {$urandom, $urandom});
        end
        a = (32'($urandom) & ~MAX_MASK) | (site & MAX_MASK);
        send(CMD_RD_MAX, a, pick_value());
      end else begin
        send(4'($urandom_range(0, 15)), $urandom, {$urandom, $urandom});
      end
      if (words_sent >= next_pause) begin
        wait_drain();
        next_pause += 500;
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d command words: %0d xor/push, %0d inc/set (%0d wraps), %0d max/min (%0d stored)",
             words_sent, mirror.cmd_hist[CMD_XOR] + mirror.cmd_hist[CMD_PUSH],
             mirror.cmd_hist[CMD_INC] + mirror.cmd_hist[CMD_SET], mirror.wraps,
             mirror.cmd_hist[CMD_MAX] + mirror.cmd_hist[CMD_MIN], mirror.stores);
    $display("%0d reads, %0d restarts, %0d unused codes; %0d results checked, %0d mismatches",
             mirror.cmd_hist[CMD_RD_CNT] + mirror.cmd_hist[CMD_RD_MAX],
             mirror.cmd_hist[CMD_RESTART], mirror.unused_cmds, mirror.answers_checked,
             mirror.errors);
    if (mirror.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/cov_rec_pkg.sv
sv/cov_rec_update.sv
sv/coverage_state_map_recorder_core.sv
tb/sv/tb_top.sv
